// ----- design/amht_pkg.sv -----
// ----------------------------------------------------------------------------
// amht_pkg
// Shared types and constants for the alpha mask hit test unit.
// ----------------------------------------------------------------------------
`default_nettype none

package amht_pkg;

  // Store geometry
  localparam int MASK_BYTES = 131072;
  localparam int ADDR_W     = $clog2(MASK_BYTES);
  localparam int MAX_LEVELS = 11;
  localparam int LVL_W      = 4;

  // Field widths fixed by the interface
  localparam int DIM_W   = 11;
  localparam int LC_W    = 4;
  localparam int MSIZE_W = 18;
  localparam int COORD_W = 20;
  localparam int RAD_W   = 20;
  localparam int FRAC_W  = 8;
  localparam int ALPHA_W = 8;
  localparam int OP_W    = 2;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 18;

  // Internal widths
  localparam int AREA_W = 2 * DIM_W;      // one level area, also j * level width
  localparam int BASE_W = AREA_W + 2;     // sum of shrinking areas stays below 4/3 of base
  localparam int WIDE_W = COORD_W + 3;    // signed box tests with radius added
  localparam int RINT_W = RAD_W - FRAC_W; // integer part of the radius

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_POINT  = 2'd1;
  localparam logic [OP_W-1:0] OP_RADIUS = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_LEVEL_COUNT  = 2'd2;
  localparam logic [CIDX_W-1:0] REG_MASK_SIZE    = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [LC_W-1:0]    level_count;
    logic [MSIZE_W-1:0] mask_size;
  } amht_cfg_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ALPHA_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } amht_ram_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_MULT,
    ST_READ,
    ST_WAIT,
    ST_DONE
  } amht_state_t;

endpackage

`default_nettype wire

// ----- design/amht_in_if.sv -----
// ----------------------------------------------------------------------------
// amht_in_if
// Input channel: load and test commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface amht_in_if;
  logic                               valid;
  logic                               ready;
  logic [amht_pkg::OP_W-1:0]          op;
  logic [amht_pkg::ADDR_W-1:0]        load_address;
  logic [amht_pkg::ALPHA_W-1:0]       load_alpha;
  logic signed [amht_pkg::COORD_W-1:0] x_coord;
  logic signed [amht_pkg::COORD_W-1:0] y_coord;
  logic [amht_pkg::RAD_W-1:0]         radius;
  logic [amht_pkg::ALPHA_W-1:0]       alpha_threshold;

  modport source (
    output valid, op, load_address, load_alpha, x_coord, y_coord, radius,
           alpha_threshold,
    input  ready
  );
  modport sink (
    input  valid, op, load_address, load_alpha, x_coord, y_coord, radius,
           alpha_threshold,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/amht_out_if.sv -----
// ----------------------------------------------------------------------------
// amht_out_if
// Result channel: hit and level fault flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface amht_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic level_fault;

  modport source (output valid, hit, level_fault, input ready);
  modport sink   (input valid, hit, level_fault, output ready);
endinterface

`default_nettype wire

// ----- design/amht_cfg_if.sv -----
// ----------------------------------------------------------------------------
// amht_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface amht_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [amht_pkg::CIDX_W-1:0]  index;
  logic [amht_pkg::CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/alpha_mask_hit_test_unit.sv -----
// ----------------------------------------------------------------------------
// alpha_mask_hit_test_unit
// Hit test against a mipmapped 8-bit alpha mask held in on-chip memory.
// ----------------------------------------------------------------------------
// One command is in flight at a time. A load, an unused op or a test that
// falls outside the image goes straight to the done state. A test that
// reaches the mask (point tests use level 0) first sums the areas of the
// lower levels through one 11x11 multiplier, then ST_MULT builds the row
// offset, ST_READ issues the read on the mask read port and ST_WAIT takes
// the registered alpha; a level fault skips the read. The result sits in
// an output register, so a new command is taken while it waits. The mask
// memory has no reset and no clearing pass: read only entries that have
// been loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_mask_hit_test_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  amht_in_if.sink    in_ch,
  amht_out_if.source out_ch,
  amht_cfg_if.sink   cfg_ch
);

  amht_pkg::amht_cfg_t          cfg_r;
  amht_pkg::amht_ram_req_t      ram_req;
  logic [amht_pkg::ALPHA_W-1:0] ram_rdata;

  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= amht_pkg::DIM_W'(1);
      cfg_r.image_height <= amht_pkg::DIM_W'(1);
      cfg_r.level_count  <= amht_pkg::LC_W'(1);
      cfg_r.mask_size    <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        amht_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_ch.data[amht_pkg::DIM_W-1:0];
        amht_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_ch.data[amht_pkg::DIM_W-1:0];
        amht_pkg::REG_LEVEL_COUNT:  cfg_r.level_count  <= cfg_ch.data[amht_pkg::LC_W-1:0];
        amht_pkg::REG_MASK_SIZE:    cfg_r.mask_size    <= cfg_ch.data[amht_pkg::MSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  amht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg       (cfg_r),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  amht_alpha_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ----- design/amht_alpha_ram.sv -----
// ----------------------------------------------------------------------------
// amht_alpha_ram
// Mask byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module amht_alpha_ram (
  input  wire logic                          clk,
  input  wire amht_pkg::amht_ram_req_t       req,
  output logic [amht_pkg::ALPHA_W-1:0]       rdata
);

  logic [amht_pkg::ALPHA_W-1:0] mem [amht_pkg::MASK_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/amht_ctrl.sv -----
// ----------------------------------------------------------------------------
// amht_ctrl
// Command sequencer: decode, level base accumulation, address build,
// mask read and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module amht_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  amht_in_if.sink                       in_ch,
  amht_out_if.source                    out_ch,
  input  wire amht_pkg::amht_cfg_t      cfg,
  output amht_pkg::amht_ram_req_t       ram_req,
  input  wire logic [amht_pkg::ALPHA_W-1:0] ram_rdata
);

  localparam int DIM_W  = amht_pkg::DIM_W;
  localparam int LVL_W  = amht_pkg::LVL_W;
  localparam int AREA_W = amht_pkg::AREA_W;
  localparam int BASE_W = amht_pkg::BASE_W;
  localparam int WIDE_W = amht_pkg::WIDE_W;
  localparam int RINT_W = amht_pkg::RINT_W;
  localparam int FRAC_W = amht_pkg::FRAC_W;
  localparam int COORD_W = amht_pkg::COORD_W;
  localparam int ADDR_W = amht_pkg::ADDR_W;

  amht_pkg::amht_state_t state_r, state_nxt;

  logic in_acc;
  logic test_go;   // accepted test that needs the mask

  // decode
  logic [DIM_W-1:0]        i_pt, j_pt, i_rt, j_rt;
  logic                    pt_miss, rt_miss;
  logic signed [WIDE_W-1:0] xs, ys, rs, wq, hq, xc, yc;
  logic [RINT_W-1:0]       r_int;
  logic [LVL_W-1:0]        lvl_raw, lc, lvl_cap;

  // datapath registers
  logic [DIM_W-1:0]        i_r, j_r, ish_r;
  logic [LVL_W-1:0]        level_r, cnt_r;
  logic [amht_pkg::ALPHA_W-1:0] thr_r;
  logic [BASE_W-1:0]       base_r;
  logic [AREA_W-1:0]       area_r, mul_r;
  logic                    oor_r;
  logic                    res_hit_r, res_fault_r;
  logic                    out_valid_r, out_hit_r, out_fault_r;

  logic [DIM_W-1:0]        aw, ah, ish, jsh;
  logic                    fault;
  logic [BASE_W-1:0]       addr_full;
  logic                    out_load;

  assign in_acc = in_ch.valid && in_ch.ready;

  // point test: truncated coordinates must land inside the base level
  always_comb begin
    i_pt    = in_ch.x_coord[COORD_W-2:FRAC_W];
    j_pt    = in_ch.y_coord[COORD_W-2:FRAC_W];
    pt_miss = in_ch.x_coord[COORD_W-1] || in_ch.y_coord[COORD_W-1] ||
              (i_pt >= cfg.image_width) || (j_pt >= cfg.image_height);
  end

  // radius test: grown box, clamp to image, level from radius
  always_comb begin
    xs = WIDE_W'(in_ch.x_coord);
    ys = WIDE_W'(in_ch.y_coord);
    rs = signed'({3'b000, in_ch.radius});
    wq = signed'({(WIDE_W-DIM_W-FRAC_W)'(0), cfg.image_width, FRAC_W'(0)});
    hq = signed'({(WIDE_W-DIM_W-FRAC_W)'(0), cfg.image_height, FRAC_W'(0)});
    rt_miss = (xs < -rs) || (ys < -rs) || (xs > wq + rs) || (ys > hq + rs);
    xc = xs;
    if (xs < 0) begin
      xc = '0;
    end else if (xs > wq) begin
      xc = wq;
    end
    yc = ys;
    if (ys < 0) begin
      yc = '0;
    end else if (ys > hq) begin
      yc = hq;
    end
    i_rt = xc[FRAC_W+DIM_W-1:FRAC_W];
    j_rt = yc[FRAC_W+DIM_W-1:FRAC_W];

    r_int   = in_ch.radius[amht_pkg::RAD_W-1:FRAC_W];
    lvl_raw = '0;
    for (int k = 1; k < RINT_W; k++) begin
      if (r_int[k]) begin
        lvl_raw = LVL_W'(k);
      end
    end
    lc = (cfg.level_count > LVL_W'(amht_pkg::MAX_LEVELS)) ?
         LVL_W'(amht_pkg::MAX_LEVELS) : cfg.level_count;
    if (lc == '0) begin
      lvl_cap = '0;
    end else if (lvl_raw >= lc) begin
      lvl_cap = lc - LVL_W'(1);
    end else begin
      lvl_cap = lvl_raw;
    end
  end

  always_comb begin
    test_go = 1'b0;
    case (in_ch.op)
      amht_pkg::OP_POINT:  test_go = !pt_miss;
      amht_pkg::OP_RADIUS: test_go = !rt_miss;
      default:             test_go = 1'b0;
    endcase
  end

  // level shift with step back at the far edge
  always_comb begin
    aw  = cfg.image_width >> level_r;
    ah  = cfg.image_height >> level_r;
    ish = i_r >> level_r;
    jsh = j_r >> level_r;
    if (ish == aw && ish != '0) begin
      ish = ish - DIM_W'(1);
    end
    if (jsh == ah && jsh != '0) begin
      jsh = jsh - DIM_W'(1);
    end
    fault     = base_r >= BASE_W'(cfg.mask_size);
    addr_full = base_r + BASE_W'(ish_r) + BASE_W'(mul_r);
    out_load  = !out_valid_r || out_ch.ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      amht_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = test_go ? amht_pkg::ST_BASE : amht_pkg::ST_DONE;
        end
      end
      amht_pkg::ST_BASE: begin
        if (cnt_r == level_r) begin
          state_nxt = amht_pkg::ST_MULT;
        end
      end
      amht_pkg::ST_MULT: state_nxt = fault ? amht_pkg::ST_DONE : amht_pkg::ST_READ;
      amht_pkg::ST_READ: state_nxt = amht_pkg::ST_WAIT;
      amht_pkg::ST_WAIT: state_nxt = amht_pkg::ST_DONE;
      amht_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = amht_pkg::ST_IDLE;
        end
      end
      default: state_nxt = amht_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready   = rst_n && (state_r == amht_pkg::ST_IDLE);
    ram_req.we    = in_acc && (in_ch.op == amht_pkg::OP_LOAD);
    ram_req.waddr = in_ch.load_address;
    ram_req.wdata = in_ch.load_alpha;
    ram_req.re    = (state_r == amht_pkg::ST_READ);
    ram_req.raddr = addr_full[ADDR_W-1:0];
    out_ch.valid       = out_valid_r;
    out_ch.hit         = out_hit_r;
    out_ch.level_fault = out_fault_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= amht_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == amht_pkg::ST_DONE && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      amht_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_hit_r   <= 1'b0;
          res_fault_r <= 1'b0;
          thr_r       <= in_ch.alpha_threshold;
          base_r      <= '0;
          area_r      <= '0;
          cnt_r       <= '0;
          if (in_ch.op == amht_pkg::OP_RADIUS) begin
            i_r     <= i_rt;
            j_r     <= j_rt;
            level_r <= lvl_cap;
          end else begin
            i_r     <= i_pt;
            j_r     <= j_pt;
            level_r <= '0;
          end
        end
      end
      amht_pkg::ST_BASE: begin
        // base lags one level behind the area product
        base_r <= base_r + BASE_W'(area_r);
        area_r <= AREA_W'(cfg.image_width >> cnt_r) * AREA_W'(cfg.image_height >> cnt_r);
        cnt_r  <= cnt_r + LVL_W'(1);
      end
      amht_pkg::ST_MULT: begin
        ish_r <= ish;
        mul_r <= AREA_W'(jsh) * AREA_W'(aw);
        if (fault) begin
          res_fault_r <= 1'b1;
        end
      end
      amht_pkg::ST_READ: begin
        oor_r <= addr_full >= BASE_W'(amht_pkg::MASK_BYTES);
      end
      amht_pkg::ST_WAIT: begin
        res_hit_r <= !oor_r && (ram_rdata > thr_r);
      end
      amht_pkg::ST_DONE: begin
        if (out_load) begin
          out_hit_r   <= res_hit_r;
          out_fault_r <= res_fault_r;
        end
      end
      default: ;
    endcase
  end

  a_no_hit_with_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_fault_r))
    else $error("hit and level fault raised together");

  a_wait_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == amht_pkg::ST_WAIT |-> $past(state_r) == amht_pkg::ST_READ)
    else $error("read data sampled without a read");

  a_base_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == amht_pkg::ST_BASE |-> cnt_r <= level_r)
    else $error("level base accumulation overran");

  a_level_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == amht_pkg::ST_MULT |-> level_r < LVL_W'(amht_pkg::MAX_LEVELS))
    else $error("level beyond the stored levels");

endmodule

`default_nettype wire
